/* hw/rtl/h2r_pkg.sv */
// ============================================================================
// h2r_pkg: constants and helpers for the HSL to RGB converter
// Field widths, hue offsets per colour lane and the reciprocal used for the
// final divide by 15300.
// ============================================================================
package h2r_pkg;

	// Field widths
	localparam int unsigned HUE_W   = 9;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned LANES   = 3;

	// Stream word widths (fields packed from bit 0, padded to whole bytes)
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 24;

	// Hue circle
	localparam int unsigned HUE_FULL = 360;

	// Internal arithmetic widths
	localparam int unsigned LEVEL_W = 16;  // V1, V2 and span, 0..65025
	localparam int unsigned WIDE_W  = 18;  // headroom for V1 / span terms
	localparam int unsigned FACT_W  = 6;   // hue factor, 0..60
	localparam int unsigned NUM_W   = 22;  // 60*V1 + span*f, up to 3901500

	// Hue breakpoints
	localparam logic [HUE_W-1:0] HUE_RISE_END = 9'd60;
	localparam logic [HUE_W-1:0] HUE_TOP_END  = 9'd180;
	localparam logic [HUE_W-1:0] HUE_FALL_END = 9'd240;
	localparam logic [FACT_W-1:0] FACT_FULL   = 6'd60;
	localparam logic [FACT_W-1:0] FACT_NONE   = 6'd0;

	// Lane offsets: red +120, green 0, blue +240 (lane 0 is red)
	localparam logic [LANES-1:0][HUE_W-1:0] LANE_HUE_OFS = {9'd240, 9'd0, 9'd120};

	// floor(n / 15300) = (n * RECIP_MULT) >> RECIP_SHIFT, exact for n < 2^22
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd4491470;
	localparam int unsigned PROD_W      = NUM_W + RECIP_W;

	// Fold a hue position of 0..719 back onto 0..359
	function automatic logic [HUE_W-1:0] hue_wrap(input logic [HUE_W:0] x);
		logic [HUE_W:0] folded;
		folded = x - (HUE_W+1)'(HUE_FULL);
		if (x >= (HUE_W+1)'(HUE_FULL)) begin
			return folded[HUE_W-1:0];
		end
		return x[HUE_W-1:0];
	endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter_core.sv */
// ============================================================================
// hsl_to_rgb_converter_core: pipelined HSL to 8-bit RGB conversion
// Four-stage pipeline, one pixel per clock, per-stage stall with bubble
// collapsing so an empty stage takes a word while the output is held.
//
//   channel  | dir | contents
//   ---------+-----+------------------------------------------------------
//   s_axis   | in  | hue_degrees[8:0], saturation[16:9], lightness[24:17]
//   m_axis   | out | red[7:0], green[15:8], blue[23:16]
//
// A taken word is registered in stage 1, then in stages 2, 3 and 4, and is
// offered on the output from stage 4; a new word is taken every cycle while
// the output side keeps up. The per-lane multiply by the hue factor and the
// reciprocal multiply for the divide by 15300 each sit in a stage of their
// own. Reset clears only the valid bits.
// A stall holds each full stage; empty stages in front still fill.
// ============================================================================
module hsl_to_rgb_converter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// hue_degrees[8:0], saturation[16:9], lightness[24:17], zero pad above
	input  logic [h2r_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// red[7:0], green[15:8], blue[23:16]
	output logic [h2r_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	// Unpack input word
	logic [h2r_pkg::HUE_W-1:0]  hue_in;
	logic [h2r_pkg::FRAC_W-1:0] sat_in;
	logic [h2r_pkg::FRAC_W-1:0] lum_in;

	assign hue_in = s_axis_tdata[8:0];
	assign sat_in = s_axis_tdata[16:9];
	assign lum_in = s_axis_tdata[24:17];

	// Stage enables: a stage advances when it is empty or the next one moves
	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en_s4 = !valid_s4 || m_axis_tready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_axis_tready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: wrap hue, lane hue positions, lightness times saturation
	// ------------------------------------------------------------------
	logic [h2r_pkg::HUE_W-1:0]                       hue_w;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::HUE_W-1:0]   lane_t;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::HUE_W-1:0]   t_s1;
	logic [h2r_pkg::LEVEL_W-1:0]                     ls_s1;
	logic [h2r_pkg::FRAC_W-1:0]                      sat_s1;
	logic [h2r_pkg::FRAC_W-1:0]                      lum_s1;

	always_comb begin
		hue_w = h2r_pkg::hue_wrap({1'b0, hue_in});
		for (int i = 0; i < h2r_pkg::LANES; i++) begin
			lane_t[i] = h2r_pkg::hue_wrap({1'b0, hue_w} + {1'b0, h2r_pkg::LANE_HUE_OFS[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			t_s1   <= lane_t;
			ls_s1  <= h2r_pkg::LEVEL_W'(lum_in) * h2r_pkg::LEVEL_W'(sat_in);
			sat_s1 <= sat_in;
			lum_s1 <= lum_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: low level V1, span V2-V1, hue factor per lane
	// ------------------------------------------------------------------
	logic [h2r_pkg::WIDE_W-1:0]                      l255;
	logic [h2r_pkg::WIDE_W-1:0]                      s255;
	logic [h2r_pkg::WIDE_W-1:0]                      ls2;
	logic [h2r_pkg::WIDE_W-1:0]                      v1_c;
	logic [h2r_pkg::WIDE_W-1:0]                      span_c;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::FACT_W-1:0]  fact_c;
	logic [h2r_pkg::HUE_W-1:0]                       fall_t;

	logic [h2r_pkg::LEVEL_W-1:0]                     v1_s2;
	logic [h2r_pkg::LEVEL_W-1:0]                     span_s2;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::FACT_W-1:0]  fact_s2;
	logic                                            zero_s2;
	logic [h2r_pkg::FRAC_W-1:0]                      lum_s2;

	always_comb begin
		l255 = h2r_pkg::WIDE_W'(lum_s1) * h2r_pkg::WIDE_W'(255);
		s255 = h2r_pkg::WIDE_W'(sat_s1) * h2r_pkg::WIDE_W'(255);
		ls2  = h2r_pkg::WIDE_W'({ls_s1, 1'b0});
		// Lightness at or below one half versus above it
		if (!lum_s1[h2r_pkg::FRAC_W-1]) begin
			v1_c   = l255 - h2r_pkg::WIDE_W'(ls_s1);
			span_c = ls2;
		end else begin
			v1_c   = l255 + h2r_pkg::WIDE_W'(ls_s1) - s255;
			span_c = {s255[h2r_pkg::WIDE_W-2:0], 1'b0} - ls2;
		end
		// Hue factor: rising edge t, top 60, falling edge 240-t, bottom 0
		for (int i = 0; i < h2r_pkg::LANES; i++) begin
			fall_t = h2r_pkg::HUE_FALL_END - t_s1[i];
			priority if (t_s1[i] < h2r_pkg::HUE_RISE_END) begin
				fact_c[i] = t_s1[i][h2r_pkg::FACT_W-1:0];
			end else if (t_s1[i] < h2r_pkg::HUE_TOP_END) begin
				fact_c[i] = h2r_pkg::FACT_FULL;
			end else if (t_s1[i] < h2r_pkg::HUE_FALL_END) begin
				fact_c[i] = fall_t[h2r_pkg::FACT_W-1:0];
			end else begin
				fact_c[i] = h2r_pkg::FACT_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			v1_s2   <= v1_c[h2r_pkg::LEVEL_W-1:0];
			span_s2 <= span_c[h2r_pkg::LEVEL_W-1:0];
			fact_s2 <= fact_c;
			zero_s2 <= (sat_s1 == '0);
			lum_s2  <= lum_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: numerator 60*V1 + span*factor per lane
	// ------------------------------------------------------------------
	logic [h2r_pkg::NUM_W-1:0]                       v1x60;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::NUM_W-1:0]   num_c;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::NUM_W-1:0]   num_s3;
	logic                                            zero_s3;
	logic [h2r_pkg::FRAC_W-1:0]                      lum_s3;

	always_comb begin
		v1x60 = h2r_pkg::NUM_W'(v1_s2) * h2r_pkg::NUM_W'(60);
		for (int i = 0; i < h2r_pkg::LANES; i++) begin
			num_c[i] = v1x60 + h2r_pkg::NUM_W'(span_s2) * h2r_pkg::NUM_W'(fact_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			num_s3  <= num_c;
			zero_s3 <= zero_s2;
			lum_s3  <= lum_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: divide by 15300 through the reciprocal, grey bypass
	// ------------------------------------------------------------------
	logic [h2r_pkg::LANES-1:0][h2r_pkg::PROD_W-1:0]  prod_c;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::CHAN_W-1:0]  chan_c;
	logic [h2r_pkg::LANES-1:0][h2r_pkg::CHAN_W-1:0]  rgb_s4;

	always_comb begin
		for (int i = 0; i < h2r_pkg::LANES; i++) begin
			prod_c[i] = h2r_pkg::PROD_W'(num_s3[i]) * h2r_pkg::PROD_W'(h2r_pkg::RECIP_MULT);
			chan_c[i] = zero_s3 ? lum_s3
				: prod_c[i][h2r_pkg::RECIP_SHIFT +: h2r_pkg::CHAN_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rgb_s4 <= chan_c;
		end
	end

	// Output word
	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = rgb_s4;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// HSL to RGB converter core testbench
// Drives HSL pixels into the stream input and checks every RGB word at the
// output against an integer-exact model of the conversion. Directed corners
// come first: grey pixels, lightness at one half, hue breakpoints and hue
// values past 359. About 900 random pixels follow. Both stream sides idle at
// random, the output is held off once for a long stretch, and the input
// pauses twice until the pipeline has drained.
// ============================================================================
module testbench;

	localparam int unsigned HALF_PERIOD = 2;
	localparam int unsigned RAND_PIXELS = 900;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TAIL_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned HOLD_AFTER  = 400;

	typedef struct packed {
		logic [h2r_pkg::HUE_W-1:0]  hue;
		logic [h2r_pkg::FRAC_W-1:0] sat;
		logic [h2r_pkg::FRAC_W-1:0] light;
	} hsl_t;

	typedef struct packed {
		logic [h2r_pkg::CHAN_W-1:0] red;
		logic [h2r_pkg::CHAN_W-1:0] green;
		logic [h2r_pkg::CHAN_W-1:0] blue;
	} rgb_t;

	// one pixel waiting to go out, with its pacing hints
	typedef struct {
		hsl_t px;
		bit   steady;      // no gap after this word
		bit   after_drain; // send only once the pipeline is empty
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [h2r_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [h2r_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	pending_t pending_px[$];
	rgb_t expected_rgb[$];
	hsl_t cur_px = '0;
	logic in_taken = 1'b0;

	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_phase = 0;
	bit rx_steady = 1'b0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;

	int unsigned error_count = 0;
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned grey_count = 0;
	int unsigned wrapped_count = 0;
	int unsigned input_stalls = 0;
	int unsigned cycle_count = 0;

	hsl_to_rgb_converter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Channel level at hue position t, levels scaled by 255*255
	function automatic logic [h2r_pkg::CHAN_W-1:0] level_at(int unsigned lo, int unsigned hi,
			int unsigned t);
		int unsigned span;
		int unsigned lvl;
		span = hi - lo;
		if (t < 60)
			lvl = (60 * lo + span * t) / 15300;
		else if (t < 180)
			lvl = hi / 255;
		else if (t < 240)
			lvl = (60 * lo + span * (240 - t)) / 15300;
		else
			lvl = lo / 255;
		return lvl[h2r_pkg::CHAN_W-1:0];
	endfunction

	// Expected RGB word for one HSL pixel
	function automatic rgb_t hsl_to_rgb(hsl_t px);
		int unsigned h;
		int unsigned s;
		int unsigned l;
		int unsigned hi;
		int unsigned lo;
		rgb_t c;
		h = 32'(px.hue);
		s = 32'(px.sat);
		l = 32'(px.light);
		if (h >= 360)
			h = h - 360;
		if (s == 0) begin
			c.red   = px.light;
			c.green = px.light;
			c.blue  = px.light;
			return c;
		end
		hi = (l <= 127) ? l * (255 + s) : 255 * (l + s) - l * s;
		lo = 510 * l - hi;
		c.red   = level_at(lo, hi, (h + 120) % 360);
		c.green = level_at(lo, hi, h);
		c.blue  = level_at(lo, hi, (h + 240) % 360);
		return c;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [h2r_pkg::FRAC_W-1:0] pick_frac();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd1;
			default: return h2r_pkg::FRAC_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_px(input int unsigned h, input int unsigned s, input int unsigned l,
			input bit steady, input bit after_drain);
		pending_t p;
		p.px.hue     = h2r_pkg::HUE_W'(h);
		p.px.sat     = h2r_pkg::FRAC_W'(s);
		p.px.light   = h2r_pkg::FRAC_W'(l);
		p.steady      = steady;
		p.after_drain = after_drain;
		pending_px.push_back(p);
	endtask

	// Clock
	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d words still expected",
				$time, cycle_count, expected_rgb.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Input driver: hold a word until taken, then idle or advance
	always @(negedge clk) begin
		pending_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !in_taken) begin
			// hold the word on offer
		end else if (tx_gap != 0) begin
			s_axis_tvalid <= 1'b0;
			tx_gap <= tx_gap - 1;
		end else if (pending_px.size() != 0 &&
				(!pending_px[0].after_drain || expected_rgb.size() == 0)) begin
			nxt = pending_px.pop_front();
			cur_px <= nxt.px;
			s_axis_tdata <= h2r_pkg::IN_DATA_W'({nxt.px.light, nxt.px.sat, nxt.px.hue});
			s_axis_tvalid <= 1'b1;
			tx_gap <= nxt.steady ? 0 : pick_gap();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Output ready: random stalls, steady stretches and one long hold-off
	always @(negedge clk) begin
		int unsigned r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_out >= HOLD_AFTER) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
		end else begin
			if (rx_phase == 0) begin
				rx_steady <= ($urandom_range(0, 2) == 0);
				rx_phase <= 63;
			end else begin
				rx_phase <= rx_phase - 1;
			end
			r = $urandom_range(0, 19);
			if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else if (rx_gap != 0) begin
				m_axis_tready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else if (r < 12) begin
				m_axis_tready <= 1'b1;
			end else if (r < 18) begin
				m_axis_tready <= 1'b0;
				rx_gap <= $urandom_range(0, 2);
			end else begin
				m_axis_tready <= 1'b0;
				rx_gap <= $urandom_range(5, 40);
			end
		end
	end

	// Predict on each input word, check each output word against the oldest
	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		bit bad;
		bad = 1'b0;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && !s_axis_tready && hold_left != 0)
			input_stalls <= input_stalls + 1;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_rgb.push_back(hsl_to_rgb(cur_px));
			words_in <= words_in + 1;
			if (cur_px.sat == 0)
				grey_count <= grey_count + 1;
			if (cur_px.hue >= h2r_pkg::HUE_FULL)
				wrapped_count <= wrapped_count + 1;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
			words_out <= words_out + 1;
			if (expected_rgb.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
				bad = 1'b1;
			end else begin
				want = expected_rgb.pop_front();
				if (got.red !== want.red) begin
					$display("%0t: red mismatch, expected %0d, actual %0d",
						$time, want.red, got.red);
					bad = 1'b1;
				end
				if (got.green !== want.green) begin
					$display("%0t: green mismatch, expected %0d, actual %0d",
						$time, want.green, got.green);
					bad = 1'b1;
				end
				if (got.blue !== want.blue) begin
					$display("%0t: blue mismatch, expected %0d, actual %0d",
						$time, want.blue, got.blue);
					bad = 1'b1;
				end
			end
		end
		if (bad)
			error_count <= error_count + 1;
	end

	// Stimulus and end of run
	initial begin
		int unsigned h;
		int unsigned r;
		bit steady;
		// grey pixels
		queue_px(0, 0, 0, 1'b0, 1'b0);
		queue_px(511, 0, 255, 1'b0, 1'b0);
		queue_px(200, 0, 127, 1'b0, 1'b0);
		// lightness either side of one half
		queue_px(30, 200, 127, 1'b0, 1'b0);
		queue_px(30, 200, 128, 1'b0, 1'b0);
		// full saturation and full or zero lightness
		queue_px(0, 255, 255, 1'b0, 1'b0);
		queue_px(0, 255, 0, 1'b0, 1'b0);
		queue_px(100, 1, 128, 1'b0, 1'b0);
		// hue breakpoints
		queue_px(59, 255, 128, 1'b1, 1'b0);
		queue_px(60, 255, 128, 1'b1, 1'b0);
		queue_px(179, 255, 128, 1'b1, 1'b0);
		queue_px(180, 255, 128, 1'b1, 1'b0);
		queue_px(239, 255, 128, 1'b1, 1'b0);
		queue_px(240, 255, 128, 1'b1, 1'b0);
		queue_px(359, 255, 128, 1'b1, 1'b0);
		queue_px(120, 180, 90, 1'b0, 1'b0);
		queue_px(300, 77, 200, 1'b0, 1'b0);
		// hue past 359 folds back
		queue_px(360, 255, 128, 1'b0, 1'b0);
		queue_px(419, 128, 64, 1'b0, 1'b0);
		queue_px(480, 255, 100, 1'b0, 1'b0);
		queue_px(511, 255, 255, 1'b0, 1'b0);
		queue_px(256, 170, 85, 1'b0, 1'b0);

		// random pixels, with runs of back-to-back words
		for (int i = 0; i < RAND_PIXELS; i++) begin
			r = $urandom_range(0, 9);
			h = (r == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
			steady = ((i % 100) < 30);
			queue_px(h, 32'(pick_frac()), 32'(pick_frac()), steady, (i == 0 || i == 600));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_px.size() != 0 || s_axis_tvalid || expected_rgb.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d pixels, %0d grey and %0d with hue past 359; %0d words checked",
			words_in, grey_count, wrapped_count, words_out);
		$display("Long output hold-off stalled the input for %0d cycles",
			input_stalls);
		if (error_count == 0 && expected_rgb.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
